>>> rtl/assert_macros.svh
// Assertion macros used by the task dependency tracker RTL.
// Each macro expects clk_i, and TDT_ASSERT also rst_ni, to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is active
`define TDT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check that also holds during reset
`define TDT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> rtl/tdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the task dependency tracker.
// No dependencies.
package tdt_pkg;

  // Default graph capacity
  localparam int MaxNodesDef = 64;

  // Request codes
  typedef enum logic [2:0] {
    REQ_ADD_NODE = 3'd0,
    REQ_ADD_EDGE = 3'd1,
    REQ_FINALIZE = 3'd2,
    REQ_RESET    = 3'd3,
    REQ_SUBMIT   = 3'd4,
    REQ_COMPLETE = 3'd5,
    REQ_LIST     = 3'd6
  } req_e;

  // Response status codes
  typedef enum logic [3:0] {
    STS_OK        = 4'd0,
    STS_LOCKED    = 4'd1,
    STS_SELF_EDGE = 4'd2,
    STS_UNKNOWN   = 4'd3,
    STS_CYCLE     = 4'd4,
    STS_NOT_FIN   = 4'd5,
    STS_NOT_READY = 4'd6,
    STS_BAD_STATE = 4'd7,
    STS_UNDERFLOW = 4'd8,
    STS_FULL      = 4'd9
  } status_e;

  // Per-node execution state
  typedef enum logic [1:0] {
    NS_PENDING   = 2'd0,
    NS_READY     = 2'd1,
    NS_SUBMITTED = 2'd2,
    NS_COMPLETED = 2'd3
  } nstat_e;

endpackage

>>> rtl/tdt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tdt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and enabled registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/task_dependency_tracker_core.sv
`timescale 1ns / 1ps
// Task dependency tracker top level: request sequencer over RAM-based graph store.
// Depends on tdt_pkg, tdt_ram and assert_macros.svh.
//
// Usage:
//  Request channel (in_valid_i/in_ready_o) carries req_type_i, node_a_i, node_b_i.
//  Result channel (out_valid_o/out_ready_i) carries status_o, node_id_o,
//  id_valid_o, all_done_o and last_o; last_o marks the final result of a request.
//  One request is in flight at a time; in_ready_o is high only while idle.
//  Reset and list ready walk every node; complete walks the node's successor
//  row. Finalize seeds counts for every node, then each node dequeued scans
//  its adjacency row one bit per cycle, pausing on each set bit to decrement
//  that successor's count; all counts live in single read-port RAMs.
//  The result register decouples the sides: a new request is taken while the
//  final result still waits; list ready stalls when the receiver is busy.
//  Reset empties the graph (no nodes, unlocked); no clearing pass is needed
//  since the successor, count and state RAM rows are written when a node is added.
`include "assert_macros.svh"

module task_dependency_tracker_core
  import tdt_pkg::*;
#(
  parameter int MaxNodes = MaxNodesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] req_type_i,
  input  logic [6:0] node_a_i,
  input  logic [6:0] node_b_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] status_o,
  output logic [6:0] node_id_o,
  output logic       id_valid_o,
  output logic       all_done_o,
  output logic       last_o
);

  localparam int IW = $clog2(MaxNodes);
  localparam int CW = $clog2(MaxNodes + 1);
  localparam int KW = (CW > 7) ? CW : 7;

  typedef enum logic [19:0] {
    S_IDLE        = 20'h00001,
    S_DISP        = 20'h00002,
    S_EDGE        = 20'h00004,
    S_FIN_INIT_RD = 20'h00008,
    S_FIN_INIT_WR = 20'h00010,
    S_FIN_POP     = 20'h00020,
    S_FIN_ROW     = 20'h00040,
    S_FIN_ROWW    = 20'h00080,
    S_FIN_SCAN    = 20'h00100,
    S_FIN_DEC     = 20'h00200,
    S_RST_RD      = 20'h00400,
    S_RST_WR      = 20'h00800,
    S_SUB         = 20'h01000,
    S_CMP_CHK     = 20'h02000,
    S_CMP_SCAN    = 20'h04000,
    S_CMP_DEC     = 20'h08000,
    S_LST_RD      = 20'h10000,
    S_LST_CHK     = 20'h20000,
    S_LST_END     = 20'h40000,
    S_RESP        = 20'h80000
  } state_e;

  state_e state_q, state_d;
  req_e   req_q, req_d;
  logic [6:0] a_q, a_d, b_q, b_d;
  logic [CW-1:0] nt_q, nt_d, done_cnt_q, done_cnt_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, head_q, head_d, tail_q, tail_d;
  logic locked_q, locked_d, found_q, found_d;
  logic [6:0] found_id_q, found_id_d;
  logic [MaxNodes-1:0] row_q, row_d;
  status_e resp_status_q, resp_status_d;
  logic [6:0] resp_id_q, resp_id_d;
  logic resp_vld_q, resp_vld_d;
  logic out_valid_q, out_valid_d;
  logic [3:0] out_status_q;
  logic [6:0] out_id_q;
  logic out_idv_q, out_done_q, out_last_q;

  // RAM ports
  logic succ_we, succ_re, pred_we, pred_re, rem_we, rem_re;
  logic stat_we, stat_re, scr_we, scr_re, que_we, que_re;
  logic [IW-1:0] succ_wa, succ_ra, pred_wa, pred_ra, rem_wa, rem_ra;
  logic [IW-1:0] stat_wa, stat_ra, scr_wa, scr_ra, que_wa, que_ra;
  logic [MaxNodes-1:0] succ_wd, succ_rd;
  logic [CW-1:0] pred_wd, pred_rd, rem_wd, rem_rd, scr_wd, scr_rd;
  logic [1:0] stat_wd, stat_rd;
  logic [IW-1:0] que_wd, que_rd;

  // Result emission
  logic emit, emit_idv, emit_last, slot_free, all_done;
  status_e emit_status;
  logic [6:0] emit_id;

  logic a_known, b_known;
  logic [IW-1:0] a_idx, b_idx, i_idx, j_idx;
  logic [MaxNodes-1:0] bit_one;

  assign a_known = (a_q != '0) && (KW'(a_q) <= KW'(nt_q));
  assign b_known = (b_q != '0) && (KW'(b_q) <= KW'(nt_q));
  assign a_idx = IW'(KW'(a_q) - KW'(1));
  assign b_idx = IW'(KW'(b_q) - KW'(1));
  assign i_idx = i_q[IW-1:0];
  assign j_idx = j_q[IW-1:0];
  assign bit_one = {{(MaxNodes-1){1'b0}}, 1'b1};
  assign slot_free = !out_valid_q || out_ready_i;
  assign all_done = locked_q && (done_cnt_q == nt_q);

  // Request sequencer
  always_comb begin
    state_d = state_q;
    req_d = req_q;
    a_d = a_q;
    b_d = b_q;
    nt_d = nt_q;
    done_cnt_d = done_cnt_q;
    i_d = i_q;
    j_d = j_q;
    head_d = head_q;
    tail_d = tail_q;
    locked_d = locked_q;
    found_d = found_q;
    found_id_d = found_id_q;
    row_d = row_q;
    resp_status_d = resp_status_q;
    resp_id_d = resp_id_q;
    resp_vld_d = resp_vld_q;
    succ_we = 1'b0; succ_re = 1'b0; succ_wa = '0; succ_ra = '0; succ_wd = '0;
    pred_we = 1'b0; pred_re = 1'b0; pred_wa = '0; pred_ra = '0; pred_wd = '0;
    rem_we = 1'b0; rem_re = 1'b0; rem_wa = '0; rem_ra = '0; rem_wd = '0;
    stat_we = 1'b0; stat_re = 1'b0; stat_wa = '0; stat_ra = '0; stat_wd = NS_PENDING;
    scr_we = 1'b0; scr_re = 1'b0; scr_wa = '0; scr_ra = '0; scr_wd = '0;
    que_we = 1'b0; que_re = 1'b0; que_wa = '0; que_ra = '0; que_wd = '0;
    emit = 1'b0;
    emit_status = STS_OK;
    emit_id = '0;
    emit_idv = 1'b0;
    emit_last = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = req_e'(req_type_i);
          a_d = node_a_i;
          b_d = node_b_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        resp_status_d = STS_OK;
        resp_id_d = '0;
        resp_vld_d = 1'b0;
        state_d = S_RESP;
        case (req_q)
          REQ_ADD_NODE: begin
            if (locked_q) begin
              resp_status_d = STS_LOCKED;
            end else if (nt_q == CW'(MaxNodes)) begin
              resp_status_d = STS_FULL;
            end else begin
              // fresh node: clear its row and counters
              succ_we = 1'b1; succ_wa = nt_q[IW-1:0];
              pred_we = 1'b1; pred_wa = nt_q[IW-1:0];
              rem_we = 1'b1; rem_wa = nt_q[IW-1:0];
              stat_we = 1'b1; stat_wa = nt_q[IW-1:0];
              nt_d = nt_q + CW'(1);
              resp_id_d = 7'(nt_q + CW'(1));
              resp_vld_d = 1'b1;
            end
          end
          REQ_ADD_EDGE: begin
            if (locked_q) begin
              resp_status_d = STS_LOCKED;
            end else if (a_q == b_q) begin
              resp_status_d = STS_SELF_EDGE;
            end else if (!(a_known && b_known)) begin
              resp_status_d = STS_UNKNOWN;
            end else begin
              succ_re = 1'b1; succ_ra = a_idx;
              pred_re = 1'b1; pred_ra = b_idx;
              state_d = S_EDGE;
            end
          end
          REQ_FINALIZE: begin
            if (!locked_q) begin
              i_d = '0;
              tail_d = '0;
              state_d = S_FIN_INIT_RD;
            end
          end
          REQ_RESET: begin
            if (!locked_q) begin
              resp_status_d = STS_NOT_FIN;
            end else begin
              i_d = '0;
              done_cnt_d = '0;
              state_d = S_RST_RD;
            end
          end
          REQ_SUBMIT: begin
            if (!locked_q) begin
              resp_status_d = STS_NOT_FIN;
            end else if (!a_known) begin
              resp_status_d = STS_UNKNOWN;
            end else begin
              stat_re = 1'b1; stat_ra = a_idx;
              state_d = S_SUB;
            end
          end
          REQ_COMPLETE: begin
            if (!locked_q) begin
              resp_status_d = STS_NOT_FIN;
            end else if (!a_known) begin
              resp_status_d = STS_UNKNOWN;
            end else begin
              stat_re = 1'b1; stat_ra = a_idx;
              succ_re = 1'b1; succ_ra = a_idx;
              state_d = S_CMP_CHK;
            end
          end
          REQ_LIST: begin
            if (!locked_q) begin
              resp_status_d = STS_NOT_FIN;
            end else begin
              i_d = '0;
              found_d = 1'b0;
              state_d = S_LST_RD;
            end
          end
          default: resp_status_d = STS_BAD_STATE;
        endcase
      end

      // Edge insert, skipped when already present
      S_EDGE: begin
        if (!succ_rd[b_idx]) begin
          succ_we = 1'b1; succ_wa = a_idx; succ_wd = succ_rd | (bit_one << b_idx);
          pred_we = 1'b1; pred_wa = b_idx; pred_wd = pred_rd + CW'(1);
        end
        state_d = S_RESP;
      end

      // Kahn: seed in-degrees and queue the sources
      S_FIN_INIT_RD: begin
        if (i_q == nt_q) begin
          head_d = '0;
          state_d = S_FIN_POP;
        end else begin
          pred_re = 1'b1; pred_ra = i_idx;
          state_d = S_FIN_INIT_WR;
        end
      end
      S_FIN_INIT_WR: begin
        scr_we = 1'b1; scr_wa = i_idx; scr_wd = pred_rd;
        if (pred_rd == '0) begin
          que_we = 1'b1; que_wa = tail_q[IW-1:0]; que_wd = i_idx;
          tail_d = tail_q + CW'(1);
        end
        i_d = i_q + CW'(1);
        state_d = S_FIN_INIT_RD;
      end

      // Kahn: dequeue next node or conclude
      S_FIN_POP: begin
        if (head_q == tail_q) begin
          if (head_q == nt_q) begin
            locked_d = 1'b1;
            i_d = '0;
            done_cnt_d = '0;
            state_d = S_RST_RD;
          end else begin
            resp_status_d = STS_CYCLE;
            state_d = S_RESP;
          end
        end else begin
          que_re = 1'b1; que_ra = head_q[IW-1:0];
          head_d = head_q + CW'(1);
          state_d = S_FIN_ROW;
        end
      end
      S_FIN_ROW: begin
        succ_re = 1'b1; succ_ra = que_rd;
        state_d = S_FIN_ROWW;
      end
      S_FIN_ROWW: begin
        row_d = succ_rd;
        j_d = '0;
        state_d = S_FIN_SCAN;
      end
      S_FIN_SCAN: begin
        if (j_q == nt_q) begin
          state_d = S_FIN_POP;
        end else if (row_q[j_idx]) begin
          scr_re = 1'b1; scr_ra = j_idx;
          state_d = S_FIN_DEC;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_FIN_DEC: begin
        if (scr_rd != '0) begin
          scr_we = 1'b1; scr_wa = j_idx; scr_wd = scr_rd - CW'(1);
          if (scr_rd == CW'(1)) begin
            que_we = 1'b1; que_wa = tail_q[IW-1:0]; que_wd = j_idx;
            tail_d = tail_q + CW'(1);
          end
        end
        j_d = j_q + CW'(1);
        state_d = S_FIN_SCAN;
      end

      // Restart: reload remaining counts and ready flags
      S_RST_RD: begin
        if (i_q == nt_q) begin
          state_d = S_RESP;
        end else begin
          pred_re = 1'b1; pred_ra = i_idx;
          state_d = S_RST_WR;
        end
      end
      S_RST_WR: begin
        rem_we = 1'b1; rem_wa = i_idx; rem_wd = pred_rd;
        stat_we = 1'b1; stat_wa = i_idx;
        stat_wd = (pred_rd == '0) ? NS_READY : NS_PENDING;
        i_d = i_q + CW'(1);
        state_d = S_RST_RD;
      end

      S_SUB: begin
        if (stat_rd != NS_READY) begin
          resp_status_d = STS_NOT_READY;
        end else begin
          stat_we = 1'b1; stat_wa = a_idx; stat_wd = NS_SUBMITTED;
        end
        state_d = S_RESP;
      end

      // Complete: mark node, then walk its successors
      S_CMP_CHK: begin
        if (stat_rd != NS_READY && stat_rd != NS_SUBMITTED) begin
          resp_status_d = STS_BAD_STATE;
          state_d = S_RESP;
        end else begin
          stat_we = 1'b1; stat_wa = a_idx; stat_wd = NS_COMPLETED;
          done_cnt_d = done_cnt_q + CW'(1);
          row_d = succ_rd;
          j_d = '0;
          state_d = S_CMP_SCAN;
        end
      end
      S_CMP_SCAN: begin
        if (j_q == nt_q) begin
          state_d = S_RESP;
        end else if (row_q[j_idx]) begin
          rem_re = 1'b1; rem_ra = j_idx;
          stat_re = 1'b1; stat_ra = j_idx;
          state_d = S_CMP_DEC;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_CMP_DEC: begin
        if (rem_rd == '0) begin
          resp_status_d = STS_UNDERFLOW;
          state_d = S_RESP;
        end else begin
          rem_we = 1'b1; rem_wa = j_idx; rem_wd = rem_rd - CW'(1);
          if (rem_rd == CW'(1)) begin
            stat_we = 1'b1; stat_wa = j_idx; stat_wd = NS_READY;
            if (stat_rd == NS_COMPLETED) begin
              done_cnt_d = done_cnt_q - CW'(1);
            end
          end
          j_d = j_q + CW'(1);
          state_d = S_CMP_SCAN;
        end
      end

      // Ready list: hold one found id back to know which is last
      S_LST_RD: begin
        if (i_q == nt_q) begin
          state_d = S_LST_END;
        end else begin
          stat_re = 1'b1; stat_ra = i_idx;
          state_d = S_LST_CHK;
        end
      end
      S_LST_CHK: begin
        if (stat_rd == NS_READY) begin
          if (!found_q || slot_free) begin
            if (found_q) begin
              emit = 1'b1;
              emit_id = found_id_q;
              emit_idv = 1'b1;
              emit_last = 1'b0;
            end
            found_d = 1'b1;
            found_id_d = 7'(i_q + CW'(1));
            i_d = i_q + CW'(1);
            state_d = S_LST_RD;
          end
        end else begin
          i_d = i_q + CW'(1);
          state_d = S_LST_RD;
        end
      end
      S_LST_END: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_id = found_q ? found_id_q : 7'd0;
          emit_idv = found_q;
          state_d = S_IDLE;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_status = resp_status_q;
          emit_id = resp_id_q;
          emit_idv = resp_vld_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = emit ? 1'b1 : (out_valid_q && !out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nt_q <= '0;
      done_cnt_q <= '0;
      locked_q <= 1'b0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nt_q <= nt_d;
      done_cnt_q <= done_cnt_d;
      locked_q <= locked_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    a_q <= a_d;
    b_q <= b_d;
    i_q <= i_d;
    j_q <= j_d;
    head_q <= head_d;
    tail_q <= tail_d;
    row_q <= row_d;
    found_id_q <= found_id_d;
    resp_status_q <= resp_status_d;
    resp_id_q <= resp_id_d;
    resp_vld_q <= resp_vld_d;
    if (emit) begin
      out_status_q <= emit_status;
      out_id_q <= emit_id;
      out_idv_q <= emit_idv;
      out_done_q <= all_done;
      out_last_q <= emit_last;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign node_id_o = out_id_q;
  assign id_valid_o = out_idv_q;
  assign all_done_o = out_done_q;
  assign last_o = out_last_q;

  // Graph storage
  tdt_ram #(.Width(MaxNodes), .Depth(MaxNodes)) u_succ (
    .clk_i, .we_i(succ_we), .waddr_i(succ_wa), .wdata_i(succ_wd),
    .re_i(succ_re), .raddr_i(succ_ra), .rdata_o(succ_rd)
  );
  tdt_ram #(.Width(CW), .Depth(MaxNodes)) u_pred (
    .clk_i, .we_i(pred_we), .waddr_i(pred_wa), .wdata_i(pred_wd),
    .re_i(pred_re), .raddr_i(pred_ra), .rdata_o(pred_rd)
  );
  tdt_ram #(.Width(CW), .Depth(MaxNodes)) u_rem (
    .clk_i, .we_i(rem_we), .waddr_i(rem_wa), .wdata_i(rem_wd),
    .re_i(rem_re), .raddr_i(rem_ra), .rdata_o(rem_rd)
  );
  tdt_ram #(.Width(2), .Depth(MaxNodes)) u_stat (
    .clk_i, .we_i(stat_we), .waddr_i(stat_wa), .wdata_i(stat_wd),
    .re_i(stat_re), .raddr_i(stat_ra), .rdata_o(stat_rd)
  );
  tdt_ram #(.Width(CW), .Depth(MaxNodes)) u_scr (
    .clk_i, .we_i(scr_we), .waddr_i(scr_wa), .wdata_i(scr_wd),
    .re_i(scr_re), .raddr_i(scr_ra), .rdata_o(scr_rd)
  );
  tdt_ram #(.Width(IW), .Depth(MaxNodes)) u_que (
    .clk_i, .we_i(que_we), .waddr_i(que_wa), .wdata_i(que_wd),
    .re_i(que_re), .raddr_i(que_ra), .rdata_o(que_rd)
  );

  // Checks
  `TDT_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
  `TDT_ASSERT(a_lock_sticky, !$fell(locked_q), "graph lock dropped")
  `TDT_ASSERT(a_done_bound, done_cnt_q <= nt_q, "completed count exceeds node count")
  `TDT_ASSERT(a_queue_order, (state_q == S_FIN_POP) |-> (head_q <= tail_q), "queue head past tail")
  `TDT_ASSERT(a_accept_disp, (in_valid_i && in_ready_o) |=> (state_q == S_DISP), "request not dispatched")
  `TDT_ASSERT_ALWAYS(a_rst_out, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule

>>> tb/task_dependency_tracker_core_test.sv
`timescale 1ns / 1ps
// Testbench for task_dependency_tracker_core: directed table, then random graph build and
// scheduling traffic, all results checked against a built-in graph scheduler model.
// Depends on tdt_pkg and the tracker RTL.
module task_dependency_tracker_core_test;
  import tdt_pkg::*;

  localparam int          NodeCap   = 64;
  localparam logic [2:0]  REQ_BAD   = 3'd7;
  localparam int          StallLim  = 20000;

  typedef struct packed {
    logic [3:0] status;
    logic [6:0] node_id;
    logic       id_valid;
    logic       all_done;
    logic       last;
  } answer_t;

  typedef struct {
    logic [2:0] req;
    logic [6:0] a;
    logic [6:0] b;
    bit         typed;
    status_e    status;
    logic [6:0] node_id;
    logic       id_valid;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] req_type_i = '0;
  logic [6:0] node_a_i = '0;
  logic [6:0] node_b_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] status_o;
  logic [6:0] node_id_o;
  logic       id_valid_o;
  logic       all_done_o;
  logic       last_o;

  task_dependency_tracker_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scheduler model state
  logic [NodeCap-1:0] succ_rows [NodeCap];
  int                 preds     [NodeCap];
  int                 remain    [NodeCap];
  nstat_e             node_st   [NodeCap];
  int                 nodes_used;
  bit                 graph_locked;

  // Expected answers, written at exp_wr and consumed at exp_rd
  answer_t exp_mem [int];
  int      exp_wr = 0;
  int      exp_rd = 0;
  int      errors;
  int      idle_in, idle_out;
  bit      start_hold;
  int      quiet_cycles;

  function automatic void queue_answer(answer_t ans);
    exp_mem[exp_wr] = ans;
    exp_wr++;
  endfunction

  function automatic bit id_known(logic [6:0] id);
    return id >= 1 && id <= nodes_used;
  endfunction

  function automatic logic graph_done();
    if (!graph_locked) return 1'b0;
    for (int i = 0; i < nodes_used; i++)
      if (node_st[i] != NS_COMPLETED) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void restart_graph();
    for (int i = 0; i < nodes_used; i++) begin
      remain[i]  = preds[i];
      node_st[i] = (preds[i] == 0) ? NS_READY : NS_PENDING;
    end
  endfunction

  // Kahn walk; locks and restarts on an acyclic graph
  function automatic status_e finalize_graph();
    int indeg [NodeCap];
    int fifo [NodeCap];
    int head, tail, seen, n;
    head = 0; tail = 0; seen = 0;
    if (graph_locked) return STS_OK;
    for (int i = 0; i < nodes_used; i++) begin
      indeg[i] = preds[i];
      if (preds[i] == 0) fifo[tail++] = i;
    end
    while (head < tail) begin
      n = fifo[head++];
      seen++;
      for (int j = 0; j < nodes_used; j++) begin
        if (!succ_rows[n][j] || indeg[j] == 0) continue;
        indeg[j]--;
        if (indeg[j] == 0 && tail < NodeCap) fifo[tail++] = j;
      end
    end
    if (seen != nodes_used) return STS_CYCLE;
    graph_locked = 1'b1;
    restart_graph();
    return STS_OK;
  endfunction

  function automatic status_e complete_node(logic [6:0] id);
    int t;
    if (!graph_locked) return STS_NOT_FIN;
    if (!id_known(id)) return STS_UNKNOWN;
    t = id - 1;
    if (node_st[t] != NS_READY && node_st[t] != NS_SUBMITTED) return STS_BAD_STATE;
    node_st[t] = NS_COMPLETED;
    for (int j = 0; j < nodes_used; j++) begin
      if (!succ_rows[t][j]) continue;
      if (remain[j] == 0) return STS_UNDERFLOW;
      remain[j]--;
      if (remain[j] == 0) node_st[j] = NS_READY;
    end
    return STS_OK;
  endfunction

  // Apply one request to the model and queue the answers it produces
  function automatic void schedule_request(logic [2:0] req, logic [6:0] a, logic [6:0] b);
    status_e    st;
    logic [6:0] id;
    logic       vld, done;
    int         cnt;
    st = STS_OK; id = '0; vld = 1'b0; cnt = 0;
    case (req)
      REQ_ADD_NODE: begin
        if (graph_locked) st = STS_LOCKED;
        else if (nodes_used >= NodeCap) st = STS_FULL;
        else begin
          succ_rows[nodes_used] = '0;
          preds[nodes_used]     = 0;
          remain[nodes_used]    = 0;
          node_st[nodes_used]   = NS_PENDING;
          nodes_used++;
          id  = 7'(nodes_used);
          vld = 1'b1;
        end
      end
      REQ_ADD_EDGE: begin
        if (graph_locked) st = STS_LOCKED;
        else if (a == b) st = STS_SELF_EDGE;
        else if (!id_known(a) || !id_known(b)) st = STS_UNKNOWN;
        else if (!succ_rows[a-1][b-1]) begin
          succ_rows[a-1][b-1] = 1'b1;
          preds[b-1]++;
        end
      end
      REQ_FINALIZE: st = finalize_graph();
      REQ_RESET: begin
        if (!graph_locked) st = STS_NOT_FIN;
        else restart_graph();
      end
      REQ_SUBMIT: begin
        if (!graph_locked) st = STS_NOT_FIN;
        else if (!id_known(a)) st = STS_UNKNOWN;
        else if (node_st[a-1] != NS_READY) st = STS_NOT_READY;
        else node_st[a-1] = NS_SUBMITTED;
      end
      REQ_COMPLETE: st = complete_node(a);
      REQ_LIST: begin
        if (!graph_locked) st = STS_NOT_FIN;
        else begin
          done = graph_done();
          for (int i = 0; i < nodes_used; i++) begin
            if (node_st[i] != NS_READY) continue;
            queue_answer('{STS_OK, 7'(i + 1), 1'b1, done, 1'b0});
            cnt++;
          end
          if (cnt == 0) queue_answer('{STS_OK, 7'd0, 1'b0, done, 1'b1});
          else exp_mem[exp_wr - 1].last = 1'b1;
          return;
        end
      end
      default: st = STS_BAD_STATE;
    endcase
    queue_answer('{st, id, vld, graph_done(), 1'b1});
  endfunction

  // Offer one request, hold it until taken, then update the model
  task automatic issue(logic [2:0] req, logic [6:0] a, logic [6:0] b,
                       bit typed = 0, answer_t fixed = '0);
    if ($urandom_range(0, 99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_in) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    node_a_i   <= a;
    node_b_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) begin
      schedule_request(req, a, b);
      exp_wr--;
      queue_answer(fixed);
    end else begin
      schedule_request(req, a, b);
    end
  endtask

  // Result side: check and randomize ready
  int hold_left = 0;
  always @(posedge clk_i) begin
    answer_t want;
    if (out_valid_o && out_ready_i) begin
      if (exp_wr == exp_rd) begin
        $error("result with nothing expected: status %0d id %0d", status_o, node_id_o);
        errors++;
      end else begin
        want = exp_mem[exp_rd];
        exp_mem.delete(exp_rd);
        exp_rd++;
        if (status_o !== want.status) begin
          $error("status expected %0d got %0d", want.status, status_o); errors++;
        end
        if (node_id_o !== want.node_id) begin
          $error("node_id expected %0d got %0d", want.node_id, node_id_o); errors++;
        end
        if (id_valid_o !== want.id_valid) begin
          $error("id_valid expected %0d got %0d", want.id_valid, id_valid_o); errors++;
        end
        if (all_done_o !== want.all_done) begin
          $error("all_done expected %0d got %0d", want.all_done, all_done_o); errors++;
        end
        if (last_o !== want.last) begin
          $error("last expected %0d got %0d", want.last, last_o); errors++;
        end
      end
    end
    if (start_hold) begin
      start_hold = 1'b0;
      hold_left  = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= idle_out);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLim) begin
      $display("FAIL");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{REQ_LIST,     7'd0,   7'd0,   1, STS_NOT_FIN,   7'd0, 1'b0},
    '{REQ_SUBMIT,   7'd1,   7'd0,   1, STS_NOT_FIN,   7'd0, 1'b0},
    '{REQ_COMPLETE, 7'd1,   7'd0,   1, STS_NOT_FIN,   7'd0, 1'b0},
    '{REQ_RESET,    7'd0,   7'd0,   1, STS_NOT_FIN,   7'd0, 1'b0},
    '{REQ_BAD,      7'd127, 7'd127, 1, STS_BAD_STATE, 7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd1,   7'd2,   1, STS_UNKNOWN,   7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd5,   7'd5,   1, STS_SELF_EDGE, 7'd0, 1'b0},
    '{REQ_ADD_NODE, 7'd0,   7'd0,   1, STS_OK,        7'd1, 1'b1},
    '{REQ_ADD_NODE, 7'd127, 7'd127, 1, STS_OK,        7'd2, 1'b1},
    '{REQ_ADD_EDGE, 7'd0,   7'd1,   1, STS_UNKNOWN,   7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd1,   7'd127, 1, STS_UNKNOWN,   7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd64,  7'd1,   1, STS_UNKNOWN,   7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd0,   7'd0,   1, STS_SELF_EDGE, 7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd1,   7'd2,   0, STS_OK,        7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd1,   7'd2,   0, STS_OK,        7'd0, 1'b0},
    '{REQ_ADD_EDGE, 7'd2,   7'd1,   0, STS_OK,        7'd0, 1'b0},
    '{REQ_LIST,     7'd0,   7'd0,   0, STS_OK,        7'd0, 1'b0}
  };

  // Stimulus
  initial begin
    int         sent, pick, lo, hi, sched_start;
    int         cand [NodeCap];
    int         cand_n;
    logic [2:0] rq;
    rst_ni <= 1'b0;
    errors = 0; quiet_cycles = 0; start_hold = 0;
    nodes_used = 0; graph_locked = 0;
    idle_in = 22; idle_out = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; a reverse edge 2->1 is never added so the graph stays acyclic
    foreach (dir_rows[i]) begin
      if (dir_rows[i].req == REQ_ADD_EDGE && dir_rows[i].a == 7'd2 && dir_rows[i].b == 7'd1)
        continue;
      issue(dir_rows[i].req, dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
            '{dir_rows[i].status, dir_rows[i].node_id, dir_rows[i].id_valid, 1'b0, 1'b1});
    end
    sent = dir_rows.size();

    // Build a full forward-edge DAG with noise mixed in
    while (nodes_used < NodeCap) begin
      if (sent == 70) begin idle_in = 50; idle_out = 22; end
      pick = $urandom_range(0, 99);
      if (pick < 45) issue(REQ_ADD_NODE, 7'($urandom), 7'($urandom));
      else if (pick < 80 && nodes_used >= 2) begin
        lo = $urandom_range(1, nodes_used - 1);
        hi = $urandom_range(lo + 1, nodes_used);
        issue(REQ_ADD_EDGE, 7'(lo), 7'(hi));
      end else begin
        // noise never adds edges, so no back edge can close a cycle
        do rq = 3'($urandom); while (rq == REQ_FINALIZE || rq == REQ_ADD_EDGE);
        issue(rq, 7'($urandom), 7'($urandom));
      end
      sent++;
    end
    issue(REQ_ADD_NODE, 7'd0, 7'd0);
    issue(REQ_FINALIZE, 7'd0, 7'd0);
    issue(REQ_FINALIZE, 7'd0, 7'd0);
    issue(REQ_ADD_EDGE, 7'd1, 7'd64);
    // Long receiver stall while requests keep coming
    start_hold = 1'b1;
    issue(REQ_LIST, 7'd0, 7'd0);
    sent += 5;
    sched_start = sent;

    // Run the locked schedule: mostly legal submits and completes
    while (sent < 210) begin
      if (sent == 70) begin idle_in = 50; idle_out = 22; end
      if (sent == sched_start + 25) begin idle_in = 0; idle_out = 0; end
      cand_n = 0;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        for (int i = 0; i < nodes_used; i++)
          if (node_st[i] == NS_READY || node_st[i] == NS_SUBMITTED) begin
            cand[cand_n] = i + 1;
            cand_n++;
          end
        if (cand_n > 0) issue(REQ_COMPLETE, 7'(cand[$urandom_range(0, cand_n-1)]), 7'($urandom));
        else issue(REQ_RESET, 7'($urandom), 7'($urandom));
      end else if (pick < 55) begin
        for (int i = 0; i < nodes_used; i++)
          if (node_st[i] == NS_READY) begin
            cand[cand_n] = i + 1;
            cand_n++;
          end
        if (cand_n > 0) issue(REQ_SUBMIT, 7'(cand[$urandom_range(0, cand_n-1)]), 7'($urandom));
        else issue(REQ_LIST, 7'($urandom), 7'($urandom));
      end else if (pick < 68) issue(REQ_LIST, 7'($urandom), 7'($urandom));
      else if (pick < 73) issue(REQ_RESET, 7'($urandom), 7'($urandom));
      else issue(3'($urandom), 7'($urandom), 7'($urandom));
      sent++;
    end
    in_valid_i <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
